>>> src/summed_area_table_engine_defines.svh
// Assertion macros shared by the summed area table checker.
// Depends on clk and rst being visible where the macros are used.
`ifndef SUMMED_AREA_TABLE_ENGINE_DEFINES_SVH
`define SUMMED_AREA_TABLE_ENGINE_DEFINES_SVH

// Condition now implies consequence in the following cycle.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition now implies consequence in the same cycle.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/sat_pkg.sv
// Shared constants, codes and control structs for the summed area table engine.
// No dependencies.
`timescale 1ns / 1ps

package sat_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 16;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = ROW_BITS + COL_BITS;
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int SUM_BITS  = 32;
  localparam int RSUM_BITS = 24;
  localparam int CFG_BITS  = 9;
  localparam int COORD_BITS = 8;

  // Function codes of an input item
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic load_start;
    logic load_finish;
    logic query_start;
    logic read_b;
    logic read_c;
    logic read_d;
    logic out_load;
  } sat_cmd_t;

  typedef struct packed {
    logic query_err;
    logic out_free;
  } sat_stat_t;

endpackage

>>> src/sat_ctrl.sv
// Sequencer for the summed area table engine: steps loads and queries.
// Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             func,
  input  sat_pkg::sat_stat_t stat,
  output sat_pkg::sat_cmd_t  cmd,
  output logic             in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ_B,
    S_READ_C,
    S_READ_D,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == sat_pkg::FUNC_LOAD) begin
            cmd.load_start = 1'b1;
            state_next     = S_WRITE;
          end else begin
            cmd.query_start = 1'b1;
            state_next      = stat.query_err ? S_FINISH : S_READ_B;
          end
        end
      end
      S_WRITE: begin
        cmd.load_finish = 1'b1;
        state_next      = S_IDLE;
      end
      S_READ_B: begin
        cmd.read_b = 1'b1;
        state_next = S_READ_C;
      end
      S_READ_C: begin
        cmd.read_c = 1'b1;
        state_next = S_READ_D;
      end
      S_READ_D: begin
        cmd.read_d = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/sat_datapath.sv
// Datapath of the summed area table engine: table memory, load counters,
// query accumulator and output register. Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic                               cfg_index,
  input  logic [sat_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic [sat_pkg::PIXEL_BITS-1:0]     pixel_value,
  input  logic [sat_pkg::COORD_BITS-1:0]     left_x,
  input  logic [sat_pkg::COORD_BITS-1:0]     top_y,
  input  logic [sat_pkg::COORD_BITS-1:0]     right_x,
  input  logic [sat_pkg::COORD_BITS-1:0]     bottom_y,
  input  sat_pkg::sat_cmd_t                  cmd,
  output sat_pkg::sat_stat_t                 stat,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [sat_pkg::SUM_BITS-1:0]       area_sum,
  output logic                               range_error
);

  logic [sat_pkg::SUM_BITS-1:0]  sat_mem [sat_pkg::DEPTH];
  logic [sat_pkg::SUM_BITS-1:0]  rdata;
  logic [sat_pkg::ADDR_BITS-1:0] raddr;
  logic                          rd_en;

  logic [sat_pkg::COL_BITS-1:0]  width_last;
  logic [sat_pkg::ROW_BITS-1:0]  height_last;
  logic [sat_pkg::COL_BITS-1:0]  col;
  logic [sat_pkg::ROW_BITS-1:0]  row;
  logic [sat_pkg::RSUM_BITS-1:0] rsum;
  logic                          complete;
  logic                          above_ok;

  logic [sat_pkg::COL_BITS-1:0]  q_left_m1;
  logic [sat_pkg::ROW_BITS-1:0]  q_top_m1;
  logic [sat_pkg::COL_BITS-1:0]  q_right;
  logic [sat_pkg::ROW_BITS-1:0]  q_bottom;
  logic                          q_left_nz;
  logic                          q_top_nz;
  logic                          q_err;
  logic [sat_pkg::SUM_BITS-1:0]  acc;
  logic [sat_pkg::SUM_BITS-1:0]  wdata;
  logic [sat_pkg::SUM_BITS-1:0]  final_sum;

  // Map a written dimension to its last valid index; zero acts as one.
  function automatic logic [sat_pkg::COL_BITS-1:0] dim_last(
    input logic [sat_pkg::CFG_BITS-1:0] v,
    input logic [sat_pkg::CFG_BITS-1:0] vmax
  );
    logic [sat_pkg::CFG_BITS-1:0] m1;
    m1 = v - 1'b1;
    if (v == '0) begin
      m1 = '0;
    end else if (v > vmax) begin
      m1 = vmax - 1'b1;
    end
    return m1[sat_pkg::COL_BITS-1:0];
  endfunction

  assign stat.query_err = !complete ||
                          (right_x > width_last) || (bottom_y > height_last) ||
                          (left_x > right_x) || (top_y > bottom_y);
  assign stat.out_free  = !out_valid || !out_stall;

  // Read address select
  always_comb begin
    rd_en = 1'b1;
    raddr = {q_top_m1, q_left_m1};
    if (cmd.load_start) begin
      raddr = {row - 1'b1, col};
    end else if (cmd.query_start) begin
      raddr = {bottom_y, right_x};
    end else if (cmd.read_b) begin
      raddr = {q_top_m1, q_right};
    end else if (cmd.read_c) begin
      raddr = {q_bottom, q_left_m1};
    end else if (!cmd.read_d) begin
      rd_en = 1'b0;
    end
  end

  assign wdata     = {{(sat_pkg::SUM_BITS-sat_pkg::RSUM_BITS){1'b0}}, rsum} +
                     (above_ok ? rdata : '0);
  assign final_sum = acc + ((q_left_nz && q_top_nz) ? rdata : '0);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= sat_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_finish) begin
      sat_mem[{row, col}] <= wdata;
    end
  end

  // Load position, running row sum and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= sat_pkg::COL_BITS'(sat_pkg::MAX_WIDTH - 1);
      height_last <= sat_pkg::ROW_BITS'(sat_pkg::MAX_HEIGHT - 1);
      col         <= '0;
      row         <= '0;
      rsum        <= '0;
      complete    <= 1'b0;
    end else if (cfg_wen) begin
      if (cfg_index == sat_pkg::REG_WIDTH) begin
        width_last <= dim_last(cfg_data, sat_pkg::CFG_BITS'(sat_pkg::MAX_WIDTH));
      end else begin
        height_last <= dim_last(cfg_data, sat_pkg::CFG_BITS'(sat_pkg::MAX_HEIGHT));
      end
      col      <= '0;
      row      <= '0;
      rsum     <= '0;
      complete <= 1'b0;
    end else if (cmd.load_start) begin
      // position is already back at the origin once a table completes
      complete <= 1'b0;
      rsum     <= rsum + sat_pkg::RSUM_BITS'(pixel_value[sat_pkg::PIXEL_BITS-1:0]);
    end else if (cmd.load_finish) begin
      if (col == width_last) begin
        col  <= '0;
        rsum <= '0;
        if (row == height_last) begin
          row      <= '0;
          complete <= 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Query operands and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      above_ok <= (row != '0);
    end
    if (cmd.query_start) begin
      q_left_m1 <= left_x - 1'b1;
      q_top_m1  <= top_y - 1'b1;
      q_right   <= right_x;
      q_bottom  <= bottom_y;
      q_left_nz <= (left_x != '0);
      q_top_nz  <= (top_y != '0);
      q_err     <= stat.query_err;
    end
    if (cmd.read_b) begin
      acc <= rdata;
    end else if (cmd.read_c) begin
      acc <= acc - (q_top_nz ? rdata : '0);
    end else if (cmd.read_d) begin
      acc <= acc - (q_left_nz ? rdata : '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      area_sum    <= q_err ? '0 : final_sum;
      range_error <= q_err;
    end
  end

endmodule

>>> src/summed_area_table_engine.sv
// Summed area table engine, top level: joins the sequencer and the datapath.
// Depends on sat_pkg, sat_ctrl and sat_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer. With
//   func = load the item supplies the next pixel in raster order; with
//   func = query it names an inclusive rectangle and yields exactly one
//   result transfer on the output channel (out_valid / out_stall) carrying
//   area_sum and range_error. Loads give no result.
//   Steps: a load reads the entry above, then writes its own table entry. A
//   valid query makes four table reads on the single read port, one per
//   cycle, then the final add; a rejected query skips the reads. The result
//   is loaded into the output register in that final step.
//   The result sits in an output register, so a new item is taken while it
//   waits. If the receiver stalls and the register is still full, a second
//   query holds in its last step until the register frees up.
//   Reset clears the load position, the running sum, the completion flag and
//   sets width and height to 256. The table memory is not cleared: entries
//   are always written by loads before any query may read them.
//   Configuration writes (cfg_wen, cfg_index, cfg_data) restart loading; the
//   user must make them only while the block is idle, it does not enforce it.
`timescale 1ns / 1ps

module summed_area_table_engine (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_wen,
  input  logic                           cfg_index,
  input  logic [sat_pkg::CFG_BITS-1:0]   cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [sat_pkg::PIXEL_BITS-1:0] pixel_value,
  input  logic [sat_pkg::COORD_BITS-1:0] left_x,
  input  logic [sat_pkg::COORD_BITS-1:0] top_y,
  input  logic [sat_pkg::COORD_BITS-1:0] right_x,
  input  logic [sat_pkg::COORD_BITS-1:0] bottom_y,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sat_pkg::SUM_BITS-1:0]   area_sum,
  output logic                           range_error
);

  sat_pkg::sat_cmd_t  cmd;
  sat_pkg::sat_stat_t stat;

  // Sequencer: decides which step the datapath performs each cycle
  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath: table memory, load counters, query accumulation, result register
  sat_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .left_x      (left_x),
    .top_y       (top_y),
    .right_x     (right_x),
    .bottom_y    (bottom_y),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .area_sum    (area_sum),
    .range_error (range_error)
  );

endmodule

>>> src/sat_checker.sv
// Port-level checks for the summed area table engine, bound to the top level.
// Depends on summed_area_table_engine_defines.svh.
`timescale 1ns / 1ps
`include "summed_area_table_engine_defines.svh"

module sat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] area_sum,
  input logic        range_error
);

  `SAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SAT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(area_sum) && $stable(range_error), "stalled result changed")
  `SAT_ASSERT_NOW(a_err_zero, out_valid && range_error, area_sum == '0, "rejected query with nonzero sum")
  `SAT_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall, "item taken with no busy cycle")

endmodule

bind summed_area_table_engine sat_checker u_sat_checker (.*);
